FILE: rtl/core/lru_key_value_cache_assert.svh
// ----------------------------------------------------------------------------
// LRU key/value cache assertion macros
// Concurrent assertion wrappers, sampled on clk_i; LKVC_ASSERT is disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH
`ifndef SYNTHESIS
`define LKVC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define LKVC_ASSERT_ANY(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define LKVC_ASSERT(name, prop, msg)
`define LKVC_ASSERT_ANY(name, prop, msg)
`endif
`endif

FILE: rtl/core/lkvc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key/value cache package
// Field widths, operation codes, controller states and command/status types.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int unsigned FuncW       = 2;
  localparam int unsigned KeyW        = 31;
  localparam int unsigned ValW        = 32;
  localparam int unsigned DefCapacity = 8;

  typedef enum logic [FuncW-1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_CLEAR  = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } state_e;

  typedef struct packed {
    logic load;     // capture the input item
    logic compare;  // search the store, plan the reorder
    logic update;   // apply the reorder, load the result
  } cmd_t;

  typedef struct packed {
    logic out_full; // result register holds an item not yet taken
  } sts_t;

endpackage

FILE: rtl/core/lkvc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key/value cache controller
// Sequences accept, compare and update, and holds the update while the
// result register is still occupied.
// ----------------------------------------------------------------------------
`include "lru_key_value_cache_assert.svh"

module lkvc_ctrl
  import lkvc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   can_retire;
  logic   accept;

  assign can_retire = !sts_i.out_full || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) || ((state_q == S_UPD) && can_retire);
  assign accept     = in_valid_i && in_ready_o;

  assign cmd_o.load    = accept;
  assign cmd_o.compare = (state_q == S_CMP);
  assign cmd_o.update  = (state_q == S_UPD) && can_retire;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_CMP;
      end
      S_CMP: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        if (can_retire) state_d = accept ? S_CMP : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `LKVC_ASSERT(a_accept_to_cmp, accept |=> (state_q == S_CMP), "accepted item did not enter compare")
  `LKVC_ASSERT(a_stall_holds, ((state_q == S_UPD) && !can_retire) |=> (state_q == S_UPD), "update left while result pending")
  `LKVC_ASSERT(a_update_fills, cmd_o.update |=> sts_i.out_full, "update did not load the result register")
  `LKVC_ASSERT(a_onehot_state, $onehot(state_q), "state register not one-hot")

endmodule

FILE: rtl/core/lkvc_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key/value cache datapath
// Recency-ordered slot row with per-slot key compare, shift/write planning
// and the result register. Slot 0 is least recent.
// ----------------------------------------------------------------------------
`include "lru_key_value_cache_assert.svh"

module lkvc_dpath
  import lkvc_pkg::*;
#(
  parameter int unsigned Capacity = DefCapacity
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cmd_t            cmd_i,
  output sts_t            sts_o,
  input  logic [FuncW-1:0] func_i,
  input  logic [KeyW-1:0] key_i,
  input  logic [ValW-1:0] value_in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            hit_o,
  output logic [ValW-1:0] value_out_o,
  output logic            evicted_o
);

  // captured item
  logic [FuncW-1:0] func_q;
  logic [KeyW-1:0]  key_q;
  logic [ValW-1:0]  val_q;

  // slot row
  logic [KeyW-1:0]     key_r [Capacity];
  logic [ValW-1:0]     val_r [Capacity];
  logic [Capacity-1:0] valid_q;

  // compare-stage plan
  logic [Capacity-1:0] match, ge_match, top, first_free;
  logic [Capacity-1:0] sh_d, sh_q, wr_d, wr_q;
  logic                hit, full;
  logic [ValW-1:0]     hval;
  logic                hit_q, evict_d, evict_q, lk_hit_d, lk_hit_q;
  logic [ValW-1:0]     wval_d, wval_q;

  // result register
  logic            out_valid_q;
  logic            hit_out_q, evict_out_q;
  logic [ValW-1:0] vout_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      key_q  <= key_i;
      val_q  <= value_in_i;
    end
  end

  always_comb begin
    hval = '0;
    for (int s = 0; s < Capacity; s++) begin
      match[s] = valid_q[s] && (key_r[s] == key_q);
      hval     = hval | ({ValW{match[s]}} & val_r[s]);
    end
    for (int s = 0; s < Capacity; s++) begin
      ge_match[s] = |(match & ({Capacity{1'b1}} >> (Capacity - 1 - s)));
    end
  end

  assign hit        = |match;
  assign full       = valid_q[Capacity-1];
  assign top        = valid_q & ~{1'b0, valid_q[Capacity-1:1]};
  assign first_free = ~valid_q & {valid_q[Capacity-2:0], 1'b1};

  always_comb begin
    sh_d     = '0;
    wr_d     = '0;
    evict_d  = 1'b0;
    lk_hit_d = 1'b0;
    wval_d   = val_q;
    unique case (func_q)
      FUNC_LOOKUP: begin
        lk_hit_d = hit;
        wval_d   = hval;
        if (hit) begin
          sh_d = ge_match;
          wr_d = top;
        end
      end
      FUNC_INSERT: begin
        if (hit) begin
          sh_d = ge_match;
          wr_d = top;
        end else if (full) begin
          // drop the least recent entry
          sh_d    = '1;
          wr_d    = top;
          evict_d = 1'b1;
        end else begin
          wr_d = first_free;
        end
      end
      FUNC_CLEAR: begin
        if (hit) sh_d = ge_match;
      end
      default: begin
        sh_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.compare) begin
      sh_q     <= sh_d;
      wr_q     <= wr_d;
      hit_q    <= hit && ((func_q == FUNC_LOOKUP) || (func_q == FUNC_INSERT) ||
                          (func_q == FUNC_CLEAR));
      evict_q  <= evict_d;
      lk_hit_q <= lk_hit_d;
      wval_q   <= wval_d;
    end
  end

  for (genvar g = 0; g < Capacity; g++) begin : g_slot
    logic [KeyW-1:0] src_key;
    logic [ValW-1:0] src_val;
    logic            src_valid;

    if (g == Capacity - 1) begin : g_top
      assign src_key   = '0;
      assign src_val   = '0;
      assign src_valid = 1'b0;
    end else begin : g_mid
      assign src_key   = key_r[g+1];
      assign src_val   = val_r[g+1];
      assign src_valid = valid_q[g+1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[g] <= 1'b0;
      end else if (cmd_i.update) begin
        if (wr_q[g]) begin
          valid_q[g] <= 1'b1;
        end else if (sh_q[g]) begin
          valid_q[g] <= src_valid;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.update) begin
        if (wr_q[g]) begin
          key_r[g] <= key_q;
          val_r[g] <= wval_q;
        end else if (sh_q[g]) begin
          key_r[g] <= src_key;
          val_r[g] <= src_val;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.update) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      hit_out_q   <= hit_q;
      evict_out_q <= evict_q;
      vout_q      <= lk_hit_q ? wval_q : '0;
    end
  end

  assign sts_o.out_full = out_valid_q;
  assign out_valid_o    = out_valid_q;
  assign hit_o          = hit_out_q;
  assign value_out_o    = vout_q;
  assign evicted_o      = evict_out_q;

  `LKVC_ASSERT(a_match_unique, $onehot0(match), "key present in more than one slot")
  `LKVC_ASSERT(a_valid_packed, (((valid_q + Capacity'(1)) & valid_q) == '0), "valid slots not packed at the least recent end")
  `LKVC_ASSERT(a_one_write, cmd_i.update |-> $onehot0(wr_q), "more than one slot planned for write")
  `LKVC_ASSERT(a_evict_full, (cmd_i.compare && evict_d) |-> full, "eviction planned on a store with room")

endmodule

FILE: rtl/core/lru_key_value_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key/value cache
// Fully associative key/value store kept in recency order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries func_i (0 lookup, 1 insert,
//   2 clear, 3 ignored), key_i and value_in_i. Output channel
//   (out_valid_o/out_ready_i) returns one item per input: hit_o, value_out_o
//   (stored word on a lookup hit, else zero) and evicted_o.
//   Each accepted item passes through a compare state (all slots in
//   parallel) and a shift/write state that loads the output register.
//   The next item can be accepted during the shift/write state of the
//   current one when the output register is free or being taken, and the
//   slot row is read and rewritten once per item.
//   When the receiver stalls, the finished result waits in the output
//   register; the following item is still accepted and compared, and its
//   update waits until the register is taken.
//   Reset empties the store (all slots invalid) and clears out_valid_o.
// ----------------------------------------------------------------------------
module lru_key_value_cache
  import lkvc_pkg::*;
#(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [FuncW-1:0] func_i,
  input  logic [KeyW-1:0] key_i,
  input  logic [ValW-1:0] value_in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            hit_o,
  output logic [ValW-1:0] value_out_o,
  output logic            evicted_o
);

  cmd_t cmd;
  sts_t sts;

  lkvc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lkvc_dpath #(
    .Capacity (CAPACITY)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .func_i      (func_i),
    .key_i       (key_i),
    .value_in_i  (value_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .hit_o       (hit_o),
    .value_out_o (value_out_o),
    .evicted_o   (evicted_o)
  );

endmodule

FILE: tb/lru_key_value_cache_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key/value cache testbench
// Drives lookup, insert, clear and unused-code items through the valid/ready
// input channel and compares every result item against a recency-ordered
// model of the store. Directed items cover empty, full, update and eviction
// cases. Random items then work a small key pool so that the store hits,
// fills and evicts often. Both sides insert random gaps, and one long
// receiver stall backs the block up.
// ----------------------------------------------------------------------------
module lru_key_value_cache_tb;
  import lkvc_pkg::*;

  localparam int unsigned CAPACITY = DefCapacity;
  localparam logic [FuncW-1:0] FuncUnused = 2'd3;
  localparam logic [KeyW-1:0] KeyMax = {KeyW{1'b1}};
  localparam logic [ValW-1:0] ValMax = {ValW{1'b1}};
  localparam int unsigned StallLimit = 500;
  localparam int unsigned LongHold = 80;
  localparam int unsigned PoolSize = 16;

  typedef struct packed {
    logic            hit;
    logic [ValW-1:0] value;
    logic            evicted;
  } cache_resp_t;

  // Recency-ordered copy of the store: slot 0 is least recent.
  class lru_scoreboard;
    logic [KeyW-1:0] slot_key[CAPACITY];
    logic [ValW-1:0] slot_val[CAPACITY];
    bit              slot_used[CAPACITY];
    cache_resp_t     expected_q[$];
    int unsigned     errors;

    function new();
      for (int s = 0; s < CAPACITY; s++) begin
        slot_key[s]  = '0;
        slot_val[s]  = '0;
        slot_used[s] = 1'b0;
      end
      errors = 0;
    endfunction

    function int used_count();
      int n;
      n = 0;
      for (int s = 0; s < CAPACITY; s++) if (slot_used[s]) n++;
      return n;
    endfunction

    function int find_slot(int n, logic [KeyW-1:0] key);
      for (int s = 0; s < n; s++) if (slot_used[s] && slot_key[s] == key) return s;
      return -1;
    endfunction

    // Drop slot pos and close the gap.
    function void drop_slot(int pos, int n);
      for (int s = pos; s + 1 < n; s++) begin
        slot_key[s]  = slot_key[s+1];
        slot_val[s]  = slot_val[s+1];
        slot_used[s] = slot_used[s+1];
      end
      if (n >= 1 && n <= CAPACITY) begin
        slot_key[n-1]  = '0;
        slot_val[n-1]  = '0;
        slot_used[n-1] = 1'b0;
      end
    endfunction

    function void put_slot(int n, logic [KeyW-1:0] key, logic [ValW-1:0] val);
      if (n >= 0 && n < CAPACITY) begin
        slot_key[n]  = key;
        slot_val[n]  = val;
        slot_used[n] = 1'b1;
      end
    endfunction

    function void note_input(logic [FuncW-1:0] func, logic [KeyW-1:0] key,
                             logic [ValW-1:0] val);
      int n;
      int pos;
      logic [ValW-1:0] stored;
      cache_resp_t r;
      r   = '0;
      n   = used_count();
      pos = find_slot(n, key);
      case (func)
        FUNC_LOOKUP: begin
          if (pos >= 0) begin
            stored  = slot_val[pos];
            r.hit   = 1'b1;
            r.value = stored;
            drop_slot(pos, n);
            put_slot(n - 1, key, stored);
          end
        end
        FUNC_INSERT: begin
          if (pos >= 0) begin
            r.hit = 1'b1;
            drop_slot(pos, n);
            put_slot(n - 1, key, val);
          end else if (n >= CAPACITY) begin
            r.evicted = 1'b1;
            drop_slot(0, CAPACITY);
            put_slot(CAPACITY - 1, key, val);
          end else begin
            put_slot(n, key, val);
          end
        end
        FUNC_CLEAR: begin
          if (pos >= 0) begin
            r.hit = 1'b1;
            drop_slot(pos, n);
          end
        end
        default: ;
      endcase
      expected_q.push_back(r);
    endfunction

    function void check_result(logic hit, logic [ValW-1:0] value, logic evicted);
      cache_resp_t want;
      if (expected_q.size() == 0) begin
        $error("result item with no expectation: hit %0d value %h evicted %0d",
               hit, value, evicted);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (hit !== want.hit) begin
        $error("hit: expected %0d, got %0d", want.hit, hit);
        errors++;
      end
      if (value !== want.value) begin
        $error("value_out: expected %h, got %h", want.value, value);
        errors++;
      end
      if (evicted !== want.evicted) begin
        $error("evicted: expected %0d, got %0d", want.evicted, evicted);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_ready_o;
  logic [FuncW-1:0] func_i;
  logic [KeyW-1:0] key_i;
  logic [ValW-1:0] value_in_i;
  logic            out_valid_o;
  logic            out_ready_i;
  logic            hit_o;
  logic [ValW-1:0] value_out_o;
  logic            evicted_o;

  lru_scoreboard   sb;
  bit              idle_on;
  bit              long_hold;
  int unsigned     idle_cycles;
  logic [KeyW-1:0] key_pool[PoolSize];

  lru_key_value_cache #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .key_i      (key_i),
    .value_in_i (value_in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .hit_o      (hit_o),
    .value_out_o(value_out_o),
    .evicted_o  (evicted_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Check results before noting inputs: a result never belongs to an item
  // accepted at the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(hit_o, value_out_o, evicted_o);
      if (in_valid_i && in_ready_o) sb.note_input(func_i, key_i, value_in_i);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_item(logic [FuncW-1:0] func, logic [KeyW-1:0] key,
                           logic [ValW-1:0] val);
    int gap;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= func;
    key_i      <= key;
    value_in_i <= val;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic send_random();
    int pick;
    int pool_len;
    logic [FuncW-1:0] func;
    logic [KeyW-1:0] key;
    pool_len = $urandom_range(4, PoolSize);
    pick = $urandom_range(0, 99);
    if (pick < 40) func = FUNC_LOOKUP;
    else if (pick < 78) func = FUNC_INSERT;
    else if (pick < 95) func = FUNC_CLEAR;
    else func = FuncUnused;
    if ($urandom_range(0, 99) < 92) key = key_pool[$urandom_range(0, pool_len - 1)];
    else key = KeyW'($urandom());
    send_item(func, key, $urandom());
  endtask

  // Receiver: random gaps per item, plus one long hold on request.
  initial begin
    int gap;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (long_hold) begin
        out_ready_i <= 1'b0;
        repeat (LongHold) @(negedge clk_i);
        long_hold = 1'b0;
      end else begin
        gap = idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
          out_ready_i <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  initial begin
    sb          = new();
    idle_on     = 1'b1;
    long_hold   = 1'b0;
    idle_cycles = 0;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    func_i     <= FUNC_LOOKUP;
    key_i      <= '0;
    value_in_i <= '0;
    key_pool[0] = '0;
    key_pool[1] = KeyMax;
    for (int i = 2; i < PoolSize; i++) key_pool[i] = KeyW'($urandom());
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty store, extremes, update in place, fill, evict, clear.
    send_item(FUNC_LOOKUP, '0, '0);
    send_item(FUNC_CLEAR, KeyMax, '0);
    send_item(FUNC_INSERT, '0, '0);
    send_item(FUNC_INSERT, KeyMax, ValMax);
    send_item(FUNC_LOOKUP, '0, ValMax);
    send_item(FUNC_LOOKUP, KeyMax, '0);
    send_item(FUNC_INSERT, '0, 32'h5A5A_5A5A);
    for (int k = 1; k <= 6; k++) send_item(FUNC_INSERT, KeyW'(k), ValW'(32'h1000_0000 + k));
    send_item(FUNC_INSERT, 31'h2AAA_AAAA, 32'hAAAA_AAAA);
    send_item(FUNC_LOOKUP, KeyMax, '0);
    send_item(FUNC_LOOKUP, '0, '0);
    send_item(FUNC_CLEAR, 31'd3, '0);
    send_item(FUNC_CLEAR, 31'd3, '0);
    send_item(FuncUnused, 31'd1, 32'h5555_5555);
    send_item(FUNC_INSERT, 31'h5555_5555, 32'h1234_5678);
    send_item(FUNC_INSERT, 31'd7, '0);
    send_item(FUNC_CLEAR, 31'h1234, '0);
    send_item(FUNC_LOOKUP, 31'd1, '0);

    for (int phase = 0; phase < 10; phase++) begin
      idle_on = (phase % 3) != 0;
      if (phase == 4) wait_drained();
      for (int i = 0; i < 65; i++) begin
        // Hold the receiver off while items keep coming so the block backs up.
        if (phase == 6 && i == 10) long_hold = 1'b1;
        send_random();
      end
    end

    wait_drained();
    repeat (10) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
